// ===== hdl/htm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// htm_pkg: shared types and constants for the HDR tone mapper
// Pixel beat formats, configuration register indexes, arithmetic constants.
// ----------------------------------------------------------------------------
package htm_pkg;

    localparam int CH_W       = 24;
    localparam int OUT_W      = 16;
    localparam int GAIN_W     = 16;
    localparam int NCH        = 3;
    localparam int LUM_W      = 24;
    localparam int RDIV_W     = 25;
    localparam int DIV_W      = 58;
    localparam int QBITS      = 16;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_TONE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WHITE = 2'd2;

    localparam logic [GAIN_W-1:0] GAIN_RESET  = 16'd256;
    localparam logic [CH_W-1:0]   WHITE_RESET = 24'd65536;
    localparam logic [CH_W-1:0]   WHITE_FLOOR = 24'd66;

    localparam logic [15:0] LUM_WR = 16'd13933;
    localparam logic [15:0] LUM_WG = 16'd46871;
    localparam logic [15:0] LUM_WB = 16'd4732;

    localparam logic [7:0]       ACES_A  = 8'd251;
    localparam logic [7:0]       ACES_B  = 8'd3;
    localparam logic [7:0]       ACES_C  = 8'd243;
    localparam logic [7:0]       ACES_D  = 8'd59;
    localparam logic [DIV_W-1:0] ACES_E  = 58'd14 << 32;

    localparam logic CURVE_REINHARD = 1'b0;
    localparam logic CURVE_ACES     = 1'b1;

    typedef struct packed {
        logic [CH_W-1:0] red_in;
        logic [CH_W-1:0] green_in;
        logic [CH_W-1:0] blue_in;
    } t_pix_in;

    typedef struct packed {
        logic [OUT_W-1:0] red_out;
        logic [OUT_W-1:0] green_out;
        logic [OUT_W-1:0] blue_out;
    } t_pix_out;

    typedef struct packed {
        logic              tone;
        logic [GAIN_W-1:0] gain;
        logic [CH_W-1:0]   white;
    } t_cfg;

    typedef struct packed {
        logic [NCH-1:0][CH_W-1:0] e;
        logic [LUM_W-1:0]         lum;
    } t_q_entry;

    typedef struct packed {
        logic full;
        logic nearly_full;
        logic empty;
    } t_q_status;

endpackage
`default_nettype wire

// ===== hdl/htm_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// htm_front: exposure and luminance front end
// Applies the exposure gain with saturation, then forms Rec.709 luminance.
// ----------------------------------------------------------------------------
module htm_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_accept,
    input  wire htm_pkg::t_pix_in  i_pixel,
    input  wire htm_pkg::t_cfg     i_cfg,
    output logic                   o_push,
    output htm_pkg::t_q_entry      o_entry
);
    import htm_pkg::*;

    logic                     r_v1;
    logic [NCH-1:0][CH_W-1:0] r_e;
    logic [NCH-1:0][CH_W-1:0] n_e;
    logic                     r_v2;
    t_q_entry                 r_entry;
    t_q_entry                 n_entry;
    logic [CH_W-1:0]          w_ch [NCH];
    logic [CH_W+GAIN_W-1:0]   w_prod [NCH];
    logic [CH_W+17:0]         w_sum;

    assign w_ch[0] = i_pixel.red_in;
    assign w_ch[1] = i_pixel.green_in;
    assign w_ch[2] = i_pixel.blue_in;

    always_comb begin
        for (int c = 0; c < NCH; c++) begin
            w_prod[c] = {{GAIN_W{1'b0}}, w_ch[c]} * {{CH_W{1'b0}}, i_cfg.gain};
            if (w_prod[c][CH_W+GAIN_W-1:CH_W+8] != '0) begin
                n_e[c] = '1;
            end else begin
                n_e[c] = w_prod[c][CH_W+7:8];
            end
        end
    end

    always_comb begin
        w_sum = {18'd0, r_e[0]} * {{CH_W+2{1'b0}}, LUM_WR}
              + {18'd0, r_e[1]} * {{CH_W+2{1'b0}}, LUM_WG}
              + {18'd0, r_e[2]} * {{CH_W+2{1'b0}}, LUM_WB};
        n_entry.e   = r_e;
        n_entry.lum = w_sum[LUM_W+15:16];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_accept;
            r_v2 <= r_v1;
        end
        r_e     <= n_e;
        r_entry <= n_entry;
    end

    assign o_push  = r_v2;
    assign o_entry = r_entry;

endmodule
`default_nettype wire

// ===== hdl/htm_fifo.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// htm_fifo: short queue between front and back end
// Holds exposed pixels and their luminance until the back end takes them.
// ----------------------------------------------------------------------------
module htm_fifo (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire htm_pkg::t_q_entry i_entry,
    input  wire logic              i_pop,
    output htm_pkg::t_q_entry      o_entry,
    output htm_pkg::t_q_status     o_status
);
    import htm_pkg::*;

    t_q_entry           r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr;
    logic [FIFO_AW-1:0] r_rd;
    logic [FIFO_AW:0]   r_cnt;
    logic [FIFO_AW:0]   n_cnt;

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= n_cnt;
        end
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    assign o_entry              = r_mem[r_rd];
    assign o_status.full        = (r_cnt == (FIFO_AW+1)'(FIFO_DEPTH));
    assign o_status.nearly_full = (r_cnt >= (FIFO_AW+1)'(FIFO_DEPTH - 2));
    assign o_status.empty       = (r_cnt == '0);

endmodule
`default_nettype wire

// ===== hdl/htm_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// htm_back: tone curve evaluation and pipelined division
// Forms numerator and divisor for the selected curve, then a sixteen-stage
// restoring divider yields the saturated Q0.16 result.
// ----------------------------------------------------------------------------
module htm_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire htm_pkg::t_q_entry i_entry,
    input  wire htm_pkg::t_cfg     i_cfg,
    output logic                   o_valid,
    output htm_pkg::t_pix_out      o_pixel
);
    import htm_pkg::*;

    logic                 r_v1;
    logic [2*CH_W-1:0]    r_prod [NCH];
    logic [CH_W-1:0]      r_e1   [NCH];
    logic [RDIV_W-1:0]    r_drn;
    logic [CH_W-1:0]      w_white;
    logic [2*CH_W-1:0]    n_prod [NCH];

    logic [DIV_W-1:0]     n_rem0 [NCH];
    logic [DIV_W-1:0]     n_d0   [NCH];
    logic [QBITS-1:0]     n_low0 [NCH];

    logic                 r_vs  [QBITS+1];
    logic [DIV_W-1:0]     r_rem [QBITS+1][NCH];
    logic [DIV_W-1:0]     r_d   [QBITS+1][NCH];
    logic [QBITS-1:0]     r_low [QBITS+1][NCH];
    logic [QBITS-1:0]     r_q   [QBITS+1][NCH];
    logic                 r_sat [QBITS+1][NCH];
    logic [DIV_W:0]       w_sh  [QBITS][NCH];
    logic [DIV_W:0]       w_df  [QBITS][NCH];
    logic                 w_ge  [QBITS][NCH];

    logic                 r_valid;
    logic [OUT_W-1:0]     r_out [NCH];
    logic [OUT_W-1:0]     n_out [NCH];

    assign w_white = (i_cfg.white < WHITE_FLOOR) ? WHITE_FLOOR : i_cfg.white;

    always_comb begin
        for (int c = 0; c < NCH; c++) begin
            if (i_cfg.tone == CURVE_ACES) begin
                n_prod[c] = {{CH_W{1'b0}}, i_entry.e[c]}
                          * {{CH_W{1'b0}}, i_entry.e[c]};
            end else begin
                n_prod[c] = {{CH_W{1'b0}}, i_entry.e[c]}
                          * {{CH_W{1'b0}}, w_white};
            end
        end
    end

    always_comb begin
        for (int c = 0; c < NCH; c++) begin
            if (i_cfg.tone == CURVE_ACES) begin
                n_rem0[c] = {10'd0, r_prod[c]} * {50'd0, ACES_A}
                          + ({34'd0, r_e1[c]} * {50'd0, ACES_B} << 16);
                n_d0[c]   = {10'd0, r_prod[c]} * {50'd0, ACES_C}
                          + ({34'd0, r_e1[c]} * {50'd0, ACES_D} << 16) + ACES_E;
                n_low0[c] = '0;
            end else begin
                n_rem0[c] = {26'd0, r_prod[c][2*CH_W-1:QBITS]};
                n_d0[c]   = {{(DIV_W-RDIV_W){1'b0}}, r_drn};
                n_low0[c] = r_prod[c][QBITS-1:0];
            end
        end
    end

    always_comb begin
        for (int s = 0; s < QBITS; s++) begin
            for (int c = 0; c < NCH; c++) begin
                w_sh[s][c] = {r_rem[s][c], r_low[s][c][QBITS-1]};
                w_df[s][c] = w_sh[s][c] - {1'b0, r_d[s][c]};
                w_ge[s][c] = (w_sh[s][c] >= {1'b0, r_d[s][c]});
            end
        end
        for (int c = 0; c < NCH; c++) begin
            n_out[c] = r_sat[QBITS][c] ? '1 : r_q[QBITS][c];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_valid <= 1'b0;
            for (int s = 0; s <= QBITS; s++) begin
                r_vs[s] <= 1'b0;
            end
        end else begin
            r_v1    <= i_valid;
            r_vs[0] <= r_v1;
            for (int s = 0; s < QBITS; s++) begin
                r_vs[s+1] <= r_vs[s];
            end
            r_valid <= r_vs[QBITS];
        end
        for (int c = 0; c < NCH; c++) begin
            r_prod[c]   <= n_prod[c];
            r_e1[c]     <= i_entry.e[c];
            r_rem[0][c] <= n_rem0[c];
            r_d[0][c]   <= n_d0[c];
            r_low[0][c] <= n_low0[c];
            r_q[0][c]   <= '0;
            r_sat[0][c] <= 1'b0;
            r_out[c]    <= n_out[c];
            for (int s = 0; s < QBITS; s++) begin
                r_rem[s+1][c] <= w_ge[s][c] ? w_df[s][c][DIV_W-1:0]
                                            : w_sh[s][c][DIV_W-1:0];
                r_d[s+1][c]   <= r_d[s][c];
                r_low[s+1][c] <= {r_low[s][c][QBITS-2:0], 1'b0};
                r_q[s+1][c]   <= {r_q[s][c][QBITS-2:0], w_ge[s][c]};
                r_sat[s+1][c] <= (s == 0) ? (r_rem[0][c] >= r_d[0][c]) : r_sat[s][c];
            end
        end
        r_drn <= {1'b0, w_white} + {1'b0, i_entry.lum};
    end

    assign o_valid           = r_valid;
    assign o_pixel.red_out   = r_out[0];
    assign o_pixel.green_out = r_out[1];
    assign o_pixel.blue_out  = r_out[2];

endmodule
`default_nettype wire

// ===== hdl/hdr_tone_mapper.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hdr_tone_mapper: Reinhard and ACES filmic tone mapping of RGB pixels
// One pixel beat is taken per clock while busy is low; each result is strobed on o_valid.
// Results pass through the exposure and luminance stages, the queue and the
// sixteen-stage divider.
// Throughput is one pixel per cycle while busy is low; the receiver cannot stall the block.
// Synchronous reset clears all valid flags and loads the register defaults.
// ----------------------------------------------------------------------------
module hdr_tone_mapper (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire htm_pkg::t_pix_in                  i_pixel,
    output logic                                   o_valid,
    output htm_pkg::t_pix_out                      o_pixel,
    input  wire logic                              i_cfg_we,
    input  wire logic [htm_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [htm_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import htm_pkg::*;

    t_cfg      r_cfg;
    logic      w_accept;
    logic      w_push;
    logic      w_pop;
    t_q_entry  w_fe;
    t_q_entry  w_be;
    t_q_status w_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tone  <= CURVE_REINHARD;
            r_cfg.gain  <= GAIN_RESET;
            r_cfg.white <= WHITE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_TONE:  r_cfg.tone  <= i_cfg_data[0];
                REG_GAIN:  r_cfg.gain  <= i_cfg_data[GAIN_W-1:0];
                REG_WHITE: r_cfg.white <= i_cfg_data[CH_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign busy     = w_stat.nearly_full;
    assign w_accept = start && !busy;
    assign w_pop    = !w_stat.empty;

    htm_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_pixel  (i_pixel),
        .i_cfg    (r_cfg),
        .o_push   (w_push),
        .o_entry  (w_fe)
    );

    htm_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_entry  (w_fe),
        .i_pop    (w_pop),
        .o_entry  (w_be),
        .o_status (w_stat)
    );

    htm_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_pop),
        .i_entry (w_be),
        .i_cfg   (r_cfg),
        .o_valid (o_valid),
        .o_pixel (o_pixel)
    );

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_stat.full)
        else $error("Queue written while full.");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(w_accept, 22))
        else $error("Result beat without a matching accepted beat.");

endmodule
`default_nettype wire

// ===== tb/hdr_tone_mapper_tb.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hdr_tone_mapper_tb: self-checking testbench for the HDR tone mapper
// A directed table of pixels, then random pixels, runs under several register
// settings. Every pixel beat is predicted in integer arithmetic and compared
// as a whole beat with the strobed result, in order.
// ----------------------------------------------------------------------------
module hdr_tone_mapper_tb;
    import htm_pkg::*;

    localparam int LATENCY   = 21;
    localparam int WDOG_MAX  = 5000;
    localparam int N_RANDOM  = 800;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct {
        t_pix_in  pix;
        logic     has_exp;
        t_pix_out exp_pix;
    } t_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    t_pix_in               i_pixel;
    logic                  o_valid;
    t_pix_out              o_pixel;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    logic              curve_sel;
    logic [GAIN_W-1:0] gain_val;
    logic [CH_W-1:0]   white_val;

    t_pix_out pending_pixels[$];
    int       mismatch_cnt;
    int       idle_cycles;
    bit       failed;

    hdr_tone_mapper uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_pixel    (i_pixel),
        .o_valid    (o_valid),
        .o_pixel    (o_pixel),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic logic [CH_W-1:0] expose_ch(logic [CH_W-1:0] ch);
        logic [63:0] p;
        p = (64'(ch) * 64'(gain_val)) >> 8;
        return (p > 64'hFFFFFF) ? 24'hFFFFFF : p[CH_W-1:0];
    endfunction

    function automatic logic [OUT_W-1:0] reinhard_ch(logic [CH_W-1:0] e,
                                                     logic [63:0] lum);
        logic [63:0] w;
        logic [63:0] q;
        w = (white_val < WHITE_FLOOR) ? 64'(WHITE_FLOOR) : 64'(white_val);
        q = (64'(e) * w) / (w + lum);
        return (q > 64'd65535) ? 16'hFFFF : q[OUT_W-1:0];
    endfunction

    function automatic logic [OUT_W-1:0] aces_ch(logic [CH_W-1:0] e);
        logic [63:0] x;
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] rem;
        logic [31:0] q;
        x   = 64'(e);
        num = x * (64'd251 * x + 64'd3 * 64'd65536);
        den = x * (64'd243 * x + 64'd59 * 64'd65536) + (64'd14 << 32);
        if (num >= den) return 16'hFFFF;
        rem = num;
        q   = 0;
        for (int i = 0; i < 16; i++) begin
            rem = rem << 1;
            q   = q << 1;
            if (rem >= den) begin
                rem  = rem - den;
                q[0] = 1'b1;
            end
        end
        return (q > 32'd65535) ? 16'hFFFF : q[OUT_W-1:0];
    endfunction

    function automatic t_pix_out tone_map(t_pix_in p);
        logic [CH_W-1:0] er, eg, eb;
        logic [63:0]     s;
        t_pix_out        r;
        er = expose_ch(p.red_in);
        eg = expose_ch(p.green_in);
        eb = expose_ch(p.blue_in);
        if (curve_sel == CURVE_REINHARD) begin
            s = 64'(LUM_WR) * er + 64'(LUM_WG) * eg + 64'(LUM_WB) * eb;
            s = s >> 16;
            r.red_out   = reinhard_ch(er, s);
            r.green_out = reinhard_ch(eg, s);
            r.blue_out  = reinhard_ch(eb, s);
        end else begin
            r.red_out   = aces_ch(er);
            r.green_out = aces_ch(eg);
            r.blue_out  = aces_ch(eb);
        end
        return r;
    endfunction

    function automatic logic [CH_W-1:0] rand_ch();
        case ($urandom_range(0, 5))
            0: return 24'h0;
            1: return 24'hFFFFFF;
            2: return CH_W'($urandom_range(0, 255));
            3: return CH_W'($urandom_range(0, 24'h3FFFF));
            default: return CH_W'($urandom);
        endcase
    endfunction

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_TONE:  curve_sel = data[0];
            REG_GAIN:  gain_val  = data[GAIN_W-1:0];
            REG_WHITE: white_val = data;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic drain_pipe();
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic random_gap();
        int n;
        n = $urandom_range(0, 99);
        if (n < 55) return;
        if (n < 95) n = $urandom_range(1, 3);
        else n = $urandom_range(10, 40);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic send_pixel(t_pix_in p, bit use_gaps);
        if (use_gaps) random_gap();
        start   <= 1'b1;
        i_pixel <= p;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pending_pixels.push_back(tone_map(p));
    endtask

    task automatic end_burst();
        start <= 1'b0;
        @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        t_pix_out exp_pix;
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            if (o_valid || (start && !busy)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (o_valid) begin
                if (pending_pixels.size() == 0) begin
                    failed = 1'b1;
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("Unexpected result beat %h", o_pixel);
                end else begin
                    exp_pix = pending_pixels.pop_front();
                    if (o_pixel !== exp_pix) begin
                        failed = 1'b1;
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10)
                            $display("Mismatch: expected r=%h g=%h b=%h, got r=%h g=%h b=%h",
                                     exp_pix.red_out, exp_pix.green_out, exp_pix.blue_out,
                                     o_pixel.red_out, o_pixel.green_out, o_pixel.blue_out);
                    end
                end
            end
            if (idle_cycles >= WDOG_MAX) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial begin
        t_row     rows[$];
        t_row     row;
        t_pix_in  p;
        t_pix_out got_exp;
        logic [CFG_DATA_W-1:0] gains[5];
        logic [CFG_DATA_W-1:0] whites[5];

        start        = 1'b0;
        i_pixel      = '0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = '0;
        i_cfg_data   = '0;
        i_rst_n      = 1'b0;
        mismatch_cnt = 0;
        failed       = 1'b0;
        curve_sel    = CURVE_REINHARD;
        gain_val     = GAIN_RESET;
        white_val    = WHITE_RESET;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table under reset settings: zero, white, saturation, mixed channels.
        rows.push_back('{'{24'h0, 24'h0, 24'h0}, 1'b1, '{16'h0, 16'h0, 16'h0}});
        rows.push_back('{'{24'h10000, 24'h10000, 24'h10000}, 1'b1,
                         '{16'h8000, 16'h8000, 16'h8000}});
        rows.push_back('{'{24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF}, 1'b0, '{default: 0}});
        rows.push_back('{'{24'hFFFFFF, 24'h0, 24'h0}, 1'b0, '{default: 0}});
        rows.push_back('{'{24'h0, 24'hFFFFFF, 24'h0}, 1'b0, '{default: 0}});
        rows.push_back('{'{24'h0, 24'h0, 24'hFFFFFF}, 1'b0, '{default: 0}});
        rows.push_back('{'{24'h000001, 24'hAAAAAA, 24'h555555}, 1'b0, '{default: 0}});
        rows.push_back('{'{24'h555555, 24'h000001, 24'hAAAAAA}, 1'b0, '{default: 0}});
        foreach (rows[i]) begin
            row = rows[i];
            if (row.has_exp) begin
                got_exp = tone_map(row.pix);
                if (got_exp !== row.exp_pix) begin
                    failed = 1'b1;
                    $display("Table row %0d disagrees with prediction", i);
                end
            end
            send_pixel(row.pix, 1'b0);
        end
        end_burst();
        drain_pipe();

        // Zero gain, tiny white level, ACES, bad register index.
        cfg_write(REG_GAIN, 24'hFF0000);
        send_pixel('{24'hFFFFFF, 24'h123456, 24'h1}, 1'b0);
        end_burst();
        drain_pipe();
        cfg_write(REG_GAIN, 24'h00FFFF);
        cfg_write(REG_WHITE, 24'h0);
        send_pixel('{24'h1, 24'h100, 24'hFFFFFF}, 1'b0);
        send_pixel('{24'h80, 24'h0, 24'h0}, 1'b0);
        end_burst();
        drain_pipe();
        cfg_write(REG_UNUSED, 24'hFFFFFF);
        cfg_write(REG_TONE, 24'hFFFFFF);
        cfg_write(REG_GAIN, 24'd256);
        send_pixel('{24'h0, 24'h0, 24'h0}, 1'b0);
        send_pixel('{24'hFFFFFF, 24'h10000, 24'h1}, 1'b0);
        send_pixel('{24'h8000, 24'h4000, 24'h2}, 1'b0);
        end_burst();
        drain_pipe();

        gains  = '{24'd0, 24'd1, 24'd256, 24'd1024, 24'hFFFF};
        whites = '{24'd0, 24'd66, 24'd65536, 24'h123456, 24'hFFFFFF};
        for (int ph = 0; ph < 8; ph++) begin
            cfg_write(REG_TONE, CFG_DATA_W'($urandom_range(0, 1)));
            cfg_write(REG_GAIN, (ph % 3 == 0) ? gains[$urandom_range(0, 4)]
                                              : CFG_DATA_W'($urandom_range(0, 2048)));
            cfg_write(REG_WHITE, (ph % 2 == 0) ? whites[$urandom_range(0, 4)]
                                               : CFG_DATA_W'($urandom));
            for (int n = 0; n < N_RANDOM / 8; n++) begin
                p.red_in   = rand_ch();
                p.green_in = rand_ch();
                p.blue_in  = rand_ch();
                send_pixel(p, ph != 3);
                if (n == N_RANDOM / 16 && ph == 5) begin
                    start <= 1'b0;
                    while (pending_pixels.size() != 0) @(posedge i_clk);
                end
            end
            end_burst();
            drain_pipe();
        end

        if (!failed && mismatch_cnt == 0 && pending_pixels.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
`default_nettype wire
